[hdl/lfr_pkg.sv]
package lfr_pkg;

   localparam int FRAME_W        = 6;
   localparam int CMD_W          = 2;
   localparam int CFG_W          = 7;
   localparam int FRAMES_DEFAULT = 64;

   localparam logic [CFG_W-1:0] ACTIVE_FRAMES_RESET = 7'd64;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD   = 2'd0,
      CMD_ACCESS = 2'd1,
      CMD_FREE   = 2'd2,
      CMD_EVICT  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_EMPTY    = 2'd1,
      STATUS_UNLISTED = 2'd2,
      STATUS_BAD_LOAD = 2'd3
   } status_type;

   typedef struct packed {
      logic [FRAME_W-1:0] victim_frame;
      logic               victim_valid;
      status_type         status;
   } rsp_type;

endpackage

[hdl/lfr_link_mem.sv]
module lfr_link_mem #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 6
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/lfr_list_ctrl.sv]
module lfr_list_ctrl #(
   parameter int FRAMES = lfr_pkg::FRAMES_DEFAULT
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_valid,
   output logic                                         req_stall,
   input  logic [lfr_pkg::CMD_W-1:0]                    req_command,
   input  logic [lfr_pkg::FRAME_W-1:0]                  req_frame,
   input  logic [lfr_pkg::CFG_W-1:0]                    active_frames,
   input  logic                                         out_free,
   output logic                                         done,
   output lfr_pkg::rsp_type                             result,
   output logic                                         rd_en,
   output logic [$clog2((FRAMES < (1 << lfr_pkg::FRAME_W)) ? FRAMES
                        : (1 << lfr_pkg::FRAME_W))-1:0] rd_addr,
   input  logic [$clog2((FRAMES < (1 << lfr_pkg::FRAME_W)) ? FRAMES
                        : (1 << lfr_pkg::FRAME_W))-1:0] next_rd_data,
   input  logic [$clog2((FRAMES < (1 << lfr_pkg::FRAME_W)) ? FRAMES
                        : (1 << lfr_pkg::FRAME_W))-1:0] prev_rd_data,
   output logic                                         next_we,
   output logic [$clog2((FRAMES < (1 << lfr_pkg::FRAME_W)) ? FRAMES
                        : (1 << lfr_pkg::FRAME_W))-1:0] next_waddr,
   output logic [$clog2((FRAMES < (1 << lfr_pkg::FRAME_W)) ? FRAMES
                        : (1 << lfr_pkg::FRAME_W))-1:0] next_wdata,
   output logic                                         prev_we,
   output logic [$clog2((FRAMES < (1 << lfr_pkg::FRAME_W)) ? FRAMES
                        : (1 << lfr_pkg::FRAME_W))-1:0] prev_waddr,
   output logic [$clog2((FRAMES < (1 << lfr_pkg::FRAME_W)) ? FRAMES
                        : (1 << lfr_pkg::FRAME_W))-1:0] prev_wdata
);

   localparam int FW    = lfr_pkg::FRAME_W;
   localparam int DEPTH = (FRAMES < (1 << FW)) ? FRAMES : (1 << FW);
   localparam int IW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_EXEC   = 3'b010,
      ST_APPEND = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   lfr_pkg::cmd_type     cmd_ff, cmd_in;
   logic [FW-1:0]        frame_ff, frame_in;
   logic [IW-1:0]        idx_ff, idx_in;
   logic [IW-1:0]        head_ff, head_in;
   logic [IW-1:0]        tail_ff, tail_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [DEPTH-1:0]     listed_ff, listed_in;

   logic                 accept;
   logic                 frame_ok;
   logic                 f_listed;
   logic                 full;
   logic                 is_head;
   logic                 is_tail;
   logic                 last;
   logic [31:0]          cap;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);

   // read both links of the addressed frame (or the head for evict) on accept
   assign rd_en   = accept;
   assign rd_addr = (lfr_pkg::cmd_type'(req_command) == lfr_pkg::CMD_EVICT) ? head_ff
                    : IW'(req_frame);

   assign frame_ok = 32'(frame_ff) < 32'(FRAMES);
   assign f_listed = frame_ok && listed_ff[idx_ff];
   assign cap      = (32'(active_frames) > 32'(FRAMES)) ? 32'(FRAMES) : 32'(active_frames);
   assign full     = 32'(count_ff) >= cap;
   assign is_head  = (idx_ff == head_ff);
   assign is_tail  = (idx_ff == tail_ff);
   assign last     = (count_ff == CW'(1));

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      frame_in   = frame_ff;
      idx_in     = idx_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      count_in   = count_ff;
      listed_in  = listed_ff;
      done       = 1'b0;
      result     = '{victim_frame: '0, victim_valid: 1'b0, status: lfr_pkg::STATUS_OK};
      next_we    = 1'b0;
      next_waddr = tail_ff;
      next_wdata = idx_ff;
      prev_we    = 1'b0;
      prev_waddr = idx_ff;
      prev_wdata = tail_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in   = lfr_pkg::cmd_type'(req_command);
               frame_in = req_frame;
               idx_in   = (lfr_pkg::cmd_type'(req_command) == lfr_pkg::CMD_EVICT) ? head_ff
                          : IW'(req_frame);
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            if (cmd_ff == lfr_pkg::CMD_ACCESS && f_listed && !is_tail) begin
               // unlink half of a move; the append follows in ST_APPEND
               if (is_head) begin
                  head_in = next_rd_data;
               end else begin
                  next_we    = 1'b1;
                  next_waddr = prev_rd_data;
                  next_wdata = next_rd_data;
               end
               prev_we    = 1'b1;
               prev_waddr = next_rd_data;
               prev_wdata = prev_rd_data;
               state_in   = ST_APPEND;
            end else if (out_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
               case (cmd_ff)
                  lfr_pkg::CMD_LOAD: begin
                     if (!frame_ok || f_listed || full) begin
                        result.status = lfr_pkg::STATUS_BAD_LOAD;
                     end else begin
                        if (count_ff == '0) begin
                           head_in = idx_ff;
                        end else begin
                           next_we = 1'b1;
                        end
                        prev_we           = 1'b1;
                        tail_in           = idx_ff;
                        listed_in[idx_ff] = 1'b1;
                        count_in          = count_ff + CW'(1);
                     end
                  end

                  lfr_pkg::CMD_ACCESS: begin
                     // a listed frame at the tail stays where it is
                     if (!f_listed) begin
                        result.status = lfr_pkg::STATUS_UNLISTED;
                     end
                  end

                  lfr_pkg::CMD_FREE: begin
                     if (f_listed) begin
                        listed_in[idx_ff] = 1'b0;
                        count_in          = count_ff - CW'(1);
                        if (last) begin
                           head_in = '0;
                           tail_in = '0;
                        end else begin
                           if (is_head) begin
                              head_in = next_rd_data;
                           end else begin
                              next_we    = 1'b1;
                              next_waddr = prev_rd_data;
                              next_wdata = next_rd_data;
                           end
                           if (is_tail) begin
                              tail_in = prev_rd_data;
                           end else begin
                              prev_we    = 1'b1;
                              prev_waddr = next_rd_data;
                              prev_wdata = prev_rd_data;
                           end
                        end
                     end
                  end

                  default: begin
                     if (count_ff == '0) begin
                        result.status = lfr_pkg::STATUS_EMPTY;
                     end else begin
                        result.victim_frame = FW'(head_ff);
                        result.victim_valid = 1'b1;
                        listed_in[idx_ff]   = 1'b0;
                        count_in            = count_ff - CW'(1);
                        if (last) begin
                           head_in = '0;
                           tail_in = '0;
                        end else begin
                           head_in = next_rd_data;
                        end
                     end
                  end
               endcase
            end
         end

         ST_APPEND: begin
            if (out_free) begin
               next_we  = 1'b1;
               prev_we  = 1'b1;
               tail_in  = idx_ff;
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         head_ff   <= '0;
         tail_ff   <= '0;
         count_ff  <= '0;
         listed_ff <= '0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         count_ff  <= count_in;
         listed_ff <= listed_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      frame_ff <= frame_in;
      idx_ff   <= idx_in;
   end

endmodule

[hdl/lru_frame_replacement.sv]
// LRU frame replacement list.
//
// Requests enter on req_* (valid/stall): a command (load, access, free,
// evict) and a frame number. Each request produces exactly one response on
// rsp_* (valid/stall) carrying the evicted frame, its valid flag and a
// status code. The list capacity is written through csr_* (valid/ready);
// write it only while no request is in flight.
//
// Each request passes through the link memories: one read of the frame's
// next/prev links, then a write-back of the neighbors' links while the
// response is registered (a move needs a second write to append at the
// tail). req_stall stays high until the engine is back in idle, so a new
// request is taken only once the last response has been registered.
//
// Reset clears head, tail, count and all membership bits and sets the
// capacity to 64; the link memories need no clearing pass. While rsp_stall
// holds a response in the output register, the next request waits in the
// engine and req_stall stays high.
module lru_frame_replacement #(
   parameter int FRAMES = lfr_pkg::FRAMES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [lfr_pkg::CMD_W-1:0]     req_command,
   input  logic [lfr_pkg::FRAME_W-1:0]   req_frame,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [lfr_pkg::FRAME_W-1:0]   rsp_victim_frame,
   output logic                          rsp_victim_valid,
   output logic [1:0]                    rsp_status,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lfr_pkg::CFG_W-1:0]     csr_data
);

   // only frames that fit the frame field can ever be listed
   localparam int FW    = lfr_pkg::FRAME_W;
   localparam int DEPTH = (FRAMES < (1 << FW)) ? FRAMES : (1 << FW);
   localparam int IW    = $clog2(DEPTH);

   logic [lfr_pkg::CFG_W-1:0] active_frames_ff, active_frames_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   lfr_pkg::rsp_type          rsp_ff, rsp_in;

   logic                      out_free;
   logic                      done;
   lfr_pkg::rsp_type          result;

   logic                      rd_en;
   logic [IW-1:0]             rd_addr;
   logic [IW-1:0]             next_rd_data;
   logic [IW-1:0]             prev_rd_data;
   logic                      next_we;
   logic [IW-1:0]             next_waddr;
   logic [IW-1:0]             next_wdata;
   logic                      prev_we;
   logic [IW-1:0]             prev_waddr;
   logic [IW-1:0]             prev_wdata;

   // capacity register: always ready
   assign csr_ready        = 1'b1;
   assign active_frames_in = (csr_valid && csr_ready) ? csr_data : active_frames_ff;

   // output slot is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_frames_ff <= lfr_pkg::ACTIVE_FRAMES_RESET;
         rsp_valid_ff     <= 1'b0;
      end else begin
         active_frames_ff <= active_frames_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // hold response payload; no reset needed
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_victim_frame = rsp_ff.victim_frame;
   assign rsp_victim_valid = rsp_ff.victim_valid;
   assign rsp_status       = rsp_ff.status;

   lfr_list_ctrl #(
      .FRAMES (FRAMES)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_command   (req_command),
      .req_frame     (req_frame),
      .active_frames (active_frames_ff),
      .out_free      (out_free),
      .done          (done),
      .result        (result),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .next_rd_data  (next_rd_data),
      .prev_rd_data  (prev_rd_data),
      .next_we       (next_we),
      .next_waddr    (next_waddr),
      .next_wdata    (next_wdata),
      .prev_we       (prev_we),
      .prev_waddr    (prev_waddr),
      .prev_wdata    (prev_wdata)
   );

   // forward links: frame -> more recently used neighbor
   lfr_link_mem #(
      .DEPTH (DEPTH),
      .WIDTH (IW)
   ) u_next_mem (
      .clock   (clock),
      .wr_en   (next_we),
      .wr_addr (next_waddr),
      .wr_data (next_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (next_rd_data)
   );

   // backward links: frame -> less recently used neighbor
   lfr_link_mem #(
      .DEPTH (DEPTH),
      .WIDTH (IW)
   ) u_prev_mem (
      .clock   (clock),
      .wr_en   (prev_we),
      .wr_addr (prev_waddr),
      .wr_data (prev_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (prev_rd_data)
   );

endmodule

[test/lru_frame_replacement_chk.sv]
`timescale 1ns / 1ps
module lru_frame_replacement_chk (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic [lfr_pkg::CMD_W-1:0]   req_command,
   input  logic [lfr_pkg::FRAME_W-1:0] req_frame,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [lfr_pkg::FRAME_W-1:0] rsp_victim_frame,
   input  logic                        rsp_victim_valid,
   input  logic [1:0]                  rsp_status,
   input  logic                        csr_valid,
   input  logic                        csr_ready,
   input  logic [lfr_pkg::CFG_W-1:0]   csr_data,
   output int                          outstanding,
   output int                          mismatches
);

   localparam int FRAME_COUNT = lfr_pkg::FRAMES_DEFAULT;

   // Shadow of the recency list: the lru_head side is the least recently used.
   logic [lfr_pkg::FRAME_W-1:0] link_next [FRAME_COUNT];
   logic [lfr_pkg::FRAME_W-1:0] link_prev [FRAME_COUNT];
   logic [FRAME_COUNT-1:0]      in_list;
   logic [lfr_pkg::FRAME_W-1:0] lru_head;
   logic [lfr_pkg::FRAME_W-1:0] mru_tail;
   logic [lfr_pkg::CFG_W-1:0]   list_size;
   logic [lfr_pkg::CFG_W-1:0]   capacity_cfg;

   lfr_pkg::rsp_type expected_rsp_q [$];
   int               fail_total = 0;

   function void detach_frame(input logic [lfr_pkg::FRAME_W-1:0] f);
      logic [lfr_pkg::FRAME_W-1:0] p;
      logic [lfr_pkg::FRAME_W-1:0] n;
      p = link_prev[f];
      n = link_next[f];
      if (f == lru_head) lru_head = n;
      else link_next[p] = n;
      if (f == mru_tail) mru_tail = p;
      else link_prev[n] = p;
      in_list[f] = 1'b0;
      list_size = list_size - lfr_pkg::CFG_W'(1);
      if (list_size == 0) begin
         lru_head = '0;
         mru_tail = '0;
      end
   endfunction

   function void attach_at_tail(input logic [lfr_pkg::FRAME_W-1:0] f);
      if (list_size == 0) begin
         lru_head = f;
         link_prev[f] = '0;
      end else begin
         link_next[mru_tail] = f;
         link_prev[f] = mru_tail;
      end
      link_next[f] = '0;
      mru_tail = f;
      in_list[f] = 1'b1;
      list_size = list_size + lfr_pkg::CFG_W'(1);
   endfunction

   function lfr_pkg::rsp_type predict_lru_response(input lfr_pkg::cmd_type cmd,
                                                   input logic [lfr_pkg::FRAME_W-1:0] f);
      lfr_pkg::rsp_type          r;
      logic [lfr_pkg::CFG_W-1:0] room;
      r.victim_frame = '0;
      r.victim_valid = 1'b0;
      r.status = lfr_pkg::STATUS_OK;
      room = (capacity_cfg > FRAME_COUNT) ? lfr_pkg::CFG_W'(FRAME_COUNT) : capacity_cfg;
      case (cmd)
         lfr_pkg::CMD_LOAD: begin
            if (in_list[f] || list_size >= room) r.status = lfr_pkg::STATUS_BAD_LOAD;
            else attach_at_tail(f);
         end
         lfr_pkg::CMD_ACCESS: begin
            if (!in_list[f]) begin
               r.status = lfr_pkg::STATUS_UNLISTED;
            end else begin
               detach_frame(f);
               attach_at_tail(f);
            end
         end
         lfr_pkg::CMD_FREE: begin
            if (in_list[f]) detach_frame(f);
         end
         default: begin
            if (list_size == 0) begin
               r.status = lfr_pkg::STATUS_EMPTY;
            end else begin
               r.victim_frame = lru_head;
               r.victim_valid = 1'b1;
               detach_frame(lru_head);
            end
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin : watch
      lfr_pkg::rsp_type want;
      if (reset) begin
         in_list = '0;
         lru_head = '0;
         mru_tail = '0;
         list_size = '0;
         capacity_cfg = lfr_pkg::ACTIVE_FRAMES_RESET;
         expected_rsp_q.delete();
         outstanding <= 0;
      end else begin
         // take responses first: one accepted at this edge can never belong to
         // a request accepted at the same edge
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               $error("response with no request outstanding: victim_frame %0d",
                      rsp_victim_frame);
               fail_total++;
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_victim_frame !== want.victim_frame) begin
                  $error("victim_frame: expected %0d, actual %0d",
                         want.victim_frame, rsp_victim_frame);
                  fail_total++;
               end
               if (rsp_victim_valid !== want.victim_valid) begin
                  $error("victim_valid: expected %0d, actual %0d",
                         want.victim_valid, rsp_victim_valid);
                  fail_total++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  fail_total++;
               end
            end
         end
         if (csr_valid && csr_ready) capacity_cfg = csr_data;
         if (req_valid && !req_stall)
            expected_rsp_q.push_back(
               predict_lru_response(lfr_pkg::cmd_type'(req_command), req_frame));
         outstanding <= expected_rsp_q.size();
      end
      mismatches <= fail_total;
   end

endmodule

[test/lru_frame_replacement_tb.sv]
`timescale 1ns / 1ps
module lru_frame_replacement_tb;

   // Cycles without any handshake before the run is declared hung. The worst
   // correct gap is a sender idle burst plus a response stall burst plus a
   // move, so this leaves a wide margin.
   localparam int QUIET_LIMIT = 2000;
   localparam int PHASE_ITEMS = 122;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [lfr_pkg::CMD_W-1:0]     req_command = lfr_pkg::CMD_LOAD;
   logic [lfr_pkg::FRAME_W-1:0]   req_frame = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [lfr_pkg::FRAME_W-1:0]   rsp_victim_frame;
   logic                          rsp_victim_valid;
   logic [1:0]                    rsp_status;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [lfr_pkg::CFG_W-1:0]     csr_data = '0;

   int outstanding;
   int mismatches;
   int quiet_cycles = 0;

   // Random idling on both channels; cleared for the last phase.
   bit idle_on = 1'b1;

   // Frames for random requests mostly come from a window, so loads, accesses
   // and frees keep hitting the same frames and the list gets reordered a lot.
   int pool_base = 0;
   int pool_span = lfr_pkg::FRAMES_DEFAULT;

   lru_frame_replacement u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_frame        (req_frame),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_victim_frame (rsp_victim_frame),
      .rsp_victim_valid (rsp_victim_valid),
      .rsp_status       (rsp_status),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data)
   );

   lru_frame_replacement_chk u_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_frame        (req_frame),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_victim_frame (rsp_victim_frame),
      .rsp_victim_valid (rsp_victim_valid),
      .rsp_status       (rsp_status),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data),
      .outstanding      (outstanding),
      .mismatches       (mismatches)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Hang detection: restart the count on any accepted request, response or
   // register write; give up once nothing has moved for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Response back-pressure: random stall bursts, each followed by an open
   // stretch, so two bursts never merge into a longer one. Every assignment
   // is followed by a wait for a clock edge.
   initial begin
      forever begin
         if (idle_on && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 30)) @(posedge clock);
      end
   end

   // Present one request and hold it until the block takes it. Valid stays
   // high afterward so back-to-back requests need no extra edge; drop it only
   // for an idle burst, which always waits for a clock edge.
   task automatic send_request(input lfr_pkg::cmd_type cmd,
                               input logic [lfr_pkg::FRAME_W-1:0] frame);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_frame   <= frame;
      do @(posedge clock); while (req_stall);
   endtask

   // Wait until every response is back. Skip an edge first so the checker's
   // count already includes a request accepted at the current edge, then
   // add a trailing wait to cover a move.
   task automatic drain();
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Change the capacity only with the block idle.
   task automatic write_capacity(input logic [lfr_pkg::CFG_W-1:0] value);
      req_valid <= 1'b0;
      drain();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Weight toward loads so the list fills and the full case is reached, with
   // enough evicts and frees to keep it churning.
   function automatic lfr_pkg::cmd_type random_command();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return lfr_pkg::CMD_LOAD;
      else if (roll < 68) return lfr_pkg::CMD_ACCESS;
      else if (roll < 80) return lfr_pkg::CMD_FREE;
      else return lfr_pkg::CMD_EVICT;
   endfunction

   function automatic logic [lfr_pkg::FRAME_W-1:0] pick_frame();
      if ($urandom_range(0, 7) == 0) return lfr_pkg::FRAME_W'($urandom);
      return lfr_pkg::FRAME_W'(pool_base + $urandom_range(0, pool_span - 1));
   endfunction

   task automatic run_phase(input logic [lfr_pkg::CFG_W-1:0] cap, input int span);
      write_capacity(cap);
      pool_span = span;
      pool_base = $urandom_range(0, lfr_pkg::FRAMES_DEFAULT - 1);
      repeat (PHASE_ITEMS) send_request(random_command(), pick_frame());
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Empty list: evict reports empty, access reports unlisted, free is a no-op.
      send_request(lfr_pkg::CMD_EVICT, 6'd63);
      send_request(lfr_pkg::CMD_ACCESS, 6'd63);
      send_request(lfr_pkg::CMD_FREE, 6'd0);
      // Fill with both frame extremes, then reload a listed frame.
      send_request(lfr_pkg::CMD_LOAD, 6'd0);
      send_request(lfr_pkg::CMD_LOAD, 6'd63);
      send_request(lfr_pkg::CMD_LOAD, 6'd0);
      send_request(lfr_pkg::CMD_LOAD, 6'd5);
      // Move the head to the tail, touch the tail, then move the head again.
      send_request(lfr_pkg::CMD_ACCESS, 6'd0);
      send_request(lfr_pkg::CMD_ACCESS, 6'd0);
      send_request(lfr_pkg::CMD_ACCESS, 6'd63);
      // Unlink the head, then drain past empty.
      send_request(lfr_pkg::CMD_FREE, 6'd5);
      send_request(lfr_pkg::CMD_EVICT, 6'd0);
      send_request(lfr_pkg::CMD_EVICT, 6'd0);
      send_request(lfr_pkg::CMD_EVICT, 6'd0);

      // One-entry list: second load is refused as full.
      write_capacity(7'd1);
      send_request(lfr_pkg::CMD_LOAD, 6'd7);
      send_request(lfr_pkg::CMD_LOAD, 6'd8);
      send_request(lfr_pkg::CMD_ACCESS, 6'd7);
      send_request(lfr_pkg::CMD_EVICT, 6'd42);

      // Zero capacity: always full.
      write_capacity(7'd0);
      send_request(lfr_pkg::CMD_LOAD, 6'd3);

      // Capacity beyond the frame count acts as the frame count.
      write_capacity(7'd127);
      send_request(lfr_pkg::CMD_LOAD, 6'd42);
      send_request(lfr_pkg::CMD_LOAD, 6'd21);
      send_request(lfr_pkg::CMD_EVICT, 6'd0);
      send_request(lfr_pkg::CMD_EVICT, 6'd0);

      // Random phases. A full list followed by a small capacity leaves the
      // count above the limit until enough frames leave.
      run_phase(7'd64, 64);
      run_phase(7'd8, $urandom_range(4, 16));
      run_phase(7'd1, $urandom_range(2, 6));
      run_phase(7'd0, $urandom_range(2, 64));
      run_phase(7'd127, $urandom_range(32, 64));
      run_phase(7'd2, $urandom_range(2, 8));
      run_phase(7'(
         $urandom_range(3, 63)), $urandom_range(2, 64));

      // Last phase runs at full rate on both sides.
      idle_on = 1'b0;
      run_phase(7'd64, $urandom_range(8, 64));

      req_valid <= 1'b0;
      drain();
      if (mismatches == 0 && outstanding == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

[lru_frame_replacement.f]
hdl/lfr_pkg.sv
hdl/lfr_link_mem.sv
hdl/lfr_list_ctrl.sv
hdl/lru_frame_replacement.sv
test/lru_frame_replacement_chk.sv
test/lru_frame_replacement_tb.sv
